>>> rtl/oggph_pkg.sv
// shared types and constants for the ogg page header parser
// no dependencies
`default_nettype none

package oggph_pkg;

  // parser phases
  localparam logic [1:0] PH_HEADER   = 2'd0;
  localparam logic [1:0] PH_SEGMENTS = 2'd1;
  localparam logic [1:0] PH_PAYLOAD  = 2'd2;
  localparam logic [1:0] PH_HALT     = 2'd3;

  // capture pattern bytes
  localparam logic [7:0] CAP_O = 8'h4f;
  localparam logic [7:0] CAP_G = 8'h67;
  localparam logic [7:0] CAP_S = 8'h53;

  localparam logic [7:0] FLAG_BOS    = 8'h02;
  localparam logic [7:0] LACE_MAX    = 8'd255;
  localparam logic [7:0] COUNT_MAX   = 8'd255;
  localparam logic [4:0] IDX_FLAGS   = 5'd5;
  localparam logic [4:0] IDX_GRAN_LO = 5'd6;
  localparam logic [4:0] IDX_GRAN_HI = 5'd13;
  localparam logic [4:0] IDX_SER_LO  = 5'd14;
  localparam logic [4:0] IDX_SER_HI  = 5'd17;
  localparam logic [4:0] IDX_SEQ_LO  = 5'd18;
  localparam logic [4:0] IDX_SEQ_HI  = 5'd21;
  localparam logic [4:0] IDX_SEGCNT  = 5'd26;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // one page descriptor
  typedef struct packed {
    logic        status;
    logic [7:0]  header_flags;
    logic [63:0] granule;
    logic [31:0] stream_serial;
    logic [31:0] page_sequence;
    logic [7:0]  segment_count;
    logic [15:0] page_length;
    logic        packet_done;
    logic        sequence_ok;
    logic        own_stream;
    logic [7:0]  stream_count;
    logic        granule_error;
  } page_desc_t;

endpackage

`default_nettype wire

>>> rtl/oggph_parser.sv
// parser state and per-byte next-state / descriptor logic
// depends on oggph_pkg
`default_nettype none

module oggph_parser
  import oggph_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  input  wire logic       stream_start,
  input  wire logic       granule_check_enable,
  output logic            emit,
  output page_desc_t      desc
);

  logic [1:0]  phase;
  logic [4:0]  header_byte_index;
  logic [7:0]  segments_left;
  logic [15:0] payload_left;
  logic [63:0] granule_shift;
  logic [31:0] serial_shift;
  logic [31:0] sequence_shift;
  logic [7:0]  flags_held;
  logic [7:0]  segment_total;
  logic [15:0] length_sum;
  logic        packet_end_seen;
  logic [31:0] chosen_serial;
  logic        serial_chosen;
  logic [31:0] expected_sequence;
  logic        continuity_good;
  logic [7:0]  bos_count;

  logic [1:0]  phase_next;
  logic [4:0]  header_byte_index_next;
  logic [7:0]  segments_left_next;
  logic [15:0] payload_left_next;
  logic [63:0] granule_shift_next;
  logic [31:0] serial_shift_next;
  logic [31:0] sequence_shift_next;
  logic [7:0]  flags_held_next;
  logic [7:0]  segment_total_next;
  logic [15:0] length_sum_next;
  logic        packet_end_seen_next;
  logic [31:0] chosen_serial_next;
  logic        serial_chosen_next;
  logic [31:0] expected_sequence_next;
  logic        continuity_good_next;
  logic [7:0]  bos_count_next;

  // state as seen after an optional stream start clear
  logic [1:0]  c_phase;
  logic [4:0]  c_idx;
  logic [7:0]  c_segleft;
  logic [15:0] c_payload;
  logic [63:0] c_granule;
  logic [31:0] c_serial;
  logic [31:0] c_seq;
  logic [7:0]  c_flags;
  logic [7:0]  c_segtotal;
  logic [15:0] c_len;
  logic        c_pend;
  logic [31:0] c_chosen;
  logic        c_chosen_f;
  logic [31:0] c_expected;
  logic        c_cont;
  logic [7:0]  c_bos;

  // page bookkeeping results
  logic        is_bos;
  logic [31:0] pg_chosen;
  logic        pg_chosen_f;
  logic [7:0]  pg_bos;
  logic        pg_cont;
  logic [31:0] pg_expected;
  logic        pg_own;
  logic        pg_gerr;

  logic        bad;
  logic        page_emit;
  logic [15:0] len_add;
  logic        pend_add;
  logic [7:0]  segleft_dec;
  logic [15:0] payload_dec;

  always_comb begin
    c_phase    = stream_start ? PH_HEADER : phase;
    c_idx      = stream_start ? 5'd0 : header_byte_index;
    c_segleft  = stream_start ? 8'd0 : segments_left;
    c_payload  = stream_start ? 16'd0 : payload_left;
    c_granule  = stream_start ? 64'd0 : granule_shift;
    c_serial   = stream_start ? 32'd0 : serial_shift;
    c_seq      = stream_start ? 32'd0 : sequence_shift;
    c_flags    = stream_start ? 8'd0 : flags_held;
    c_segtotal = stream_start ? 8'd0 : segment_total;
    c_len      = stream_start ? 16'd0 : length_sum;
    c_pend     = stream_start ? 1'b0 : packet_end_seen;
    c_chosen   = stream_start ? 32'd0 : chosen_serial;
    c_chosen_f = stream_start ? 1'b0 : serial_chosen;
    c_expected = stream_start ? 32'd0 : expected_sequence;
    c_cont     = stream_start ? 1'b1 : continuity_good;
    c_bos      = stream_start ? 8'd0 : bos_count;
  end

  // descriptor bookkeeping, applied only when a page is emitted
  always_comb begin
    is_bos      = (c_flags & FLAG_BOS) != 8'd0;
    pg_chosen   = (is_bos && !c_chosen_f) ? c_serial : c_chosen;
    pg_chosen_f = c_chosen_f | is_bos;
    pg_bos      = (is_bos && c_bos != COUNT_MAX) ? c_bos + 8'd1 : c_bos;
    pg_cont     = c_cont && (c_seq == c_expected);
    pg_expected = pg_cont ? c_expected + 32'd1 : c_expected;
    pg_own      = pg_chosen_f && (c_serial == pg_chosen);
    pg_gerr     = granule_check_enable && pg_own && (c_granule != 64'd0)
                  && (c_granule != {64{1'b1}});
  end

  always_comb begin
    len_add     = c_len + {8'd0, data_byte};
    pend_add    = c_pend | (data_byte < LACE_MAX);
    segleft_dec = c_segleft - 8'd1;
    payload_dec = c_payload - 16'd1;

    case (c_idx)
      5'd0:       bad = data_byte != CAP_O;
      5'd1, 5'd2: bad = data_byte != CAP_G;
      5'd3:       bad = data_byte != CAP_S;
      default:    bad = 1'b0;
    endcase

    phase_next             = c_phase;
    header_byte_index_next = c_idx;
    segments_left_next     = c_segleft;
    payload_left_next      = c_payload;
    granule_shift_next     = c_granule;
    serial_shift_next      = c_serial;
    sequence_shift_next    = c_seq;
    flags_held_next        = c_flags;
    segment_total_next     = c_segtotal;
    length_sum_next        = c_len;
    packet_end_seen_next   = c_pend;
    chosen_serial_next     = c_chosen;
    serial_chosen_next     = c_chosen_f;
    expected_sequence_next = c_expected;
    continuity_good_next   = c_cont;
    bos_count_next         = c_bos;
    emit                   = 1'b0;
    page_emit              = 1'b0;

    desc = '0;

    case (c_phase)
      PH_HEADER: begin
        if (bad) begin
          emit                   = 1'b1;
          desc.status            = STATUS_BAD;
          phase_next             = PH_HALT;
          header_byte_index_next = 5'd0;
        end else if (c_idx >= IDX_SEGCNT) begin
          header_byte_index_next = 5'd0;
          segment_total_next     = data_byte;
          segments_left_next     = data_byte;
          length_sum_next        = 16'd0;
          packet_end_seen_next   = 1'b0;
          payload_left_next      = 16'd0;
          if (data_byte == 8'd0) begin
            page_emit = 1'b1;
          end else begin
            phase_next = PH_SEGMENTS;
          end
        end else begin
          header_byte_index_next = c_idx + 5'd1;
          if (c_idx == IDX_FLAGS) begin
            flags_held_next = data_byte;
          end else if (c_idx >= IDX_GRAN_LO && c_idx <= IDX_GRAN_HI) begin
            granule_shift_next = {data_byte, c_granule[63:8]};
          end else if (c_idx >= IDX_SER_LO && c_idx <= IDX_SER_HI) begin
            serial_shift_next = {data_byte, c_serial[31:8]};
          end else if (c_idx >= IDX_SEQ_LO && c_idx <= IDX_SEQ_HI) begin
            sequence_shift_next = {data_byte, c_seq[31:8]};
          end
        end
      end
      PH_SEGMENTS: begin
        length_sum_next      = len_add;
        packet_end_seen_next = pend_add;
        segments_left_next   = segleft_dec;
        if (segleft_dec == 8'd0) begin
          page_emit         = 1'b1;
          payload_left_next = len_add;
          phase_next        = (len_add == 16'd0) ? PH_HEADER : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        payload_left_next = payload_dec;
        if (payload_dec == 16'd0) begin
          phase_next = PH_HEADER;
        end
      end
      default: begin
      end
    endcase

    if (page_emit) begin
      emit                   = 1'b1;
      chosen_serial_next     = pg_chosen;
      serial_chosen_next     = pg_chosen_f;
      bos_count_next         = pg_bos;
      continuity_good_next   = pg_cont;
      expected_sequence_next = pg_expected;
      desc.status            = STATUS_OK;
      desc.header_flags      = c_flags;
      desc.granule           = c_granule;
      desc.stream_serial     = c_serial;
      desc.page_sequence     = c_seq;
      desc.segment_count     = segment_total_next;
      desc.page_length       = length_sum_next;
      desc.packet_done       = packet_end_seen_next;
      desc.sequence_ok       = pg_cont;
      desc.own_stream        = pg_own;
      desc.stream_count      = pg_bos;
      desc.granule_error     = pg_gerr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      header_byte_index <= 5'd0;
      segments_left     <= 8'd0;
      payload_left      <= 16'd0;
      granule_shift     <= 64'd0;
      serial_shift      <= 32'd0;
      sequence_shift    <= 32'd0;
      flags_held        <= 8'd0;
      segment_total     <= 8'd0;
      length_sum        <= 16'd0;
      packet_end_seen   <= 1'b0;
      chosen_serial     <= 32'd0;
      serial_chosen     <= 1'b0;
      expected_sequence <= 32'd0;
      continuity_good   <= 1'b1;
      bos_count         <= 8'd0;
    end else if (step) begin
      phase             <= phase_next;
      header_byte_index <= header_byte_index_next;
      segments_left     <= segments_left_next;
      payload_left      <= payload_left_next;
      granule_shift     <= granule_shift_next;
      serial_shift      <= serial_shift_next;
      sequence_shift    <= sequence_shift_next;
      flags_held        <= flags_held_next;
      segment_total     <= segment_total_next;
      length_sum        <= length_sum_next;
      packet_end_seen   <= packet_end_seen_next;
      chosen_serial     <= chosen_serial_next;
      serial_chosen     <= serial_chosen_next;
      expected_sequence <= expected_sequence_next;
      continuity_good   <= continuity_good_next;
      bos_count         <= bos_count_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/oggph_out_reg.sv
// result register holding one page descriptor beat
// depends on oggph_pkg
`default_nettype none

module oggph_out_reg
  import oggph_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire page_desc_t  desc_in,
  input  wire logic        page_stall,
  output logic             page_valid,
  output page_desc_t       desc_out,
  output logic             free
);

  // slot can take a beat if empty or draining this cycle
  assign free = !page_valid || !page_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_valid <= 1'b0;
    end else if (load) begin
      page_valid <= 1'b1;
    end else if (!page_stall) begin
      page_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc_out <= desc_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ogg_page_header_parser_top.sv
// top level of the ogg page header parser: input register, config register,
// parser core and result register; depends on oggph_pkg, oggph_parser,
// oggph_out_reg
//
//   channel   handshake               payload
//   byte      byte_valid/byte_stall   data_byte, stream_start
//   page      page_valid/page_stall   status ... granule_error
//   cfg       cfg_valid/cfg_ready     cfg_data (granule_check_enable)
//
// one stream byte per cycle sustained unless a page stall holds a byte; a
// byte waits in the input register, the parser state and descriptor are
// computed from it in one pass and loaded into the result register when the
// byte moves on; the descriptor is valid once it is in the result register
// rst is synchronous and active high; it clears the parser state and sets
// granule_check_enable to one; cfg_ready is always high
// a page stall holds a byte in the input register only if it would emit
`default_nettype none

module ogg_page_header_parser_top
  import oggph_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // byte channel
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        stream_start,
  // config channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  // page channel
  output logic             page_valid,
  input  wire logic        page_stall,
  output logic             status,
  output logic [7:0]       header_flags,
  output logic [63:0]      granule,
  output logic [31:0]      stream_serial,
  output logic [31:0]      page_sequence,
  output logic [7:0]       segment_count,
  output logic [15:0]      page_length,
  output logic             packet_done,
  output logic             sequence_ok,
  output logic             own_stream,
  output logic [7:0]       stream_count,
  output logic             granule_error
);

  logic       granule_check_enable;

  // input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_start;

  logic       emit;
  logic       advance;
  logic       out_free;
  logic       accept;
  page_desc_t desc;
  page_desc_t desc_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      granule_check_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      granule_check_enable <= cfg_data;
    end
  end

  // a held byte moves on unless it emits and the result slot is blocked
  assign advance    = in_full && (!emit || out_free);
  assign byte_stall = in_full && !advance;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte  <= data_byte;
      in_start <= stream_start;
    end
  end

  oggph_parser u_parser (
    .clk                  (clk),
    .rst                  (rst),
    .step                 (advance),
    .data_byte            (in_byte),
    .stream_start         (in_start),
    .granule_check_enable (granule_check_enable),
    .emit                 (emit),
    .desc                 (desc)
  );

  oggph_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && emit),
    .desc_in    (desc),
    .page_stall (page_stall),
    .page_valid (page_valid),
    .desc_out   (desc_q),
    .free       (out_free)
  );

  // unpack the descriptor beat
  assign status        = desc_q.status;
  assign header_flags  = desc_q.header_flags;
  assign granule       = desc_q.granule;
  assign stream_serial = desc_q.stream_serial;
  assign page_sequence = desc_q.page_sequence;
  assign segment_count = desc_q.segment_count;
  assign page_length   = desc_q.page_length;
  assign packet_done   = desc_q.packet_done;
  assign sequence_ok   = desc_q.sequence_ok;
  assign own_stream    = desc_q.own_stream;
  assign stream_count  = desc_q.stream_count;
  assign granule_error = desc_q.granule_error;

endmodule

`default_nettype wire
